// ===== rtl/o2hbp_pkg.sv =====
// package for the order-2 hashed bit predictor
// sizes, count limit, word kinds and table entry layout; no dependencies
`timescale 1ns / 1ps

package o2hbp_pkg;

	// count table geometry
	localparam int TABLE_ENTRIES = 65536;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int HASH_W        = 16;

	// bit counts held per entry
	localparam int COUNT_W     = 10;
	localparam int COUNT_LIMIT = 1000;
	localparam int SUM_W       = COUNT_W + 1;

	// probability scale, a power of two
	localparam int PROB_SCALE = 4096;
	localparam int QUOT_W     = $clog2(PROB_SCALE);
	localparam int PROB_W     = 13;
	localparam int STEP_W     = $clog2(QUOT_W + 1);

	// word kinds carried on tuser
	localparam logic OP_PREDICT = 1'b0;
	localparam logic OP_UPDATE  = 1'b1;

	// one table entry: zero count in the low half, one count in the high half
	typedef struct packed {
		logic [COUNT_W-1:0] n1;
		logic [COUNT_W-1:0] n0;
	} entry_t;

endpackage

// ===== rtl/o2hbp_div.sv =====
// restoring radix-2 divider for the probability quotient
// uses o2hbp_pkg for count and quotient widths
`timescale 1ns / 1ps

module o2hbp_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [o2hbp_pkg::COUNT_W-1:0]     numer,
	input  logic [o2hbp_pkg::SUM_W-1:0]       denom,
	output logic                              done,
	output logic [o2hbp_pkg::QUOT_W-1:0]      quot
);

	logic [o2hbp_pkg::SUM_W-1:0]  rem_q;
	logic [o2hbp_pkg::SUM_W-1:0]  den_q;
	logic [o2hbp_pkg::QUOT_W-1:0] quot_q;
	logic [o2hbp_pkg::STEP_W-1:0] step_q;
	logic                         run_q;
	logic                         done_q;
	logic [o2hbp_pkg::SUM_W:0]    shifted;
	logic                         fits;

	// one shift, compare and subtract step
	assign shifted = {rem_q, 1'b0};
	assign fits    = shifted >= {1'b0, den_q};

	// control: step counter and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			step_q <= o2hbp_pkg::STEP_W'(o2hbp_pkg::QUOT_W);
		end else if (run_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == o2hbp_pkg::STEP_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath: remainder and quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, numer};
			den_q  <= denom;
			quot_q <= '0;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= o2hbp_pkg::SUM_W'(shifted - {1'b0, den_q});
			end else begin
				rem_q <= shifted[o2hbp_pkg::SUM_W-1:0];
			end
			quot_q <= {quot_q[o2hbp_pkg::QUOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== rtl/order2_hashed_bit_predictor.sv =====
// top level of the order-2 hashed bit predictor: handshake, sequencer, count table
// depends on o2hbp_pkg and o2hbp_div
`timescale 1ns / 1ps

// A predict word (tuser 0) hashes ((older*257 + previous)*31) xor partial into
// a 16-bit index into a 65536-entry table of zero/one counts, remembers the
// index and returns n1*4096/(n0+n1). An update word (tuser 1) bumps the count
// of the coded bit at the remembered index, halving both counts with rounding
// up once that count passes 1000; it returns nothing. After reset the block
// writes both counts of every entry to 1, one entry a cycle, and takes no
// word until that pass is done. A predict then goes through its steps in
// order: the bytes are summed as the word is taken, then the hash and table
// read, the divider load, the restoring divider at one quotient bit per
// cycle, and the registering of the result; the block is ready again on the
// next cycle. An update reads the entry, then writes it back updated. One
// word is in flight at a time; the result register lets the next word in
// while a result still waits, and a finished predict stays in its last step
// until the result register is free.

module order2_hashed_bit_predictor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] older_byte, [15:8] previous_byte, [23:16] partial_byte,
	// [24] coded_bit, [31:25] zero
	input  logic [31:0] s_axis_tdata,
	// [0] operation
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [12:0] probability_one, [15:13] zero
	output logic [15:0] m_axis_tdata
);

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;
	localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
	localparam logic [ST_W-1:0] ST_HASH  = 3'd2;
	localparam logic [ST_W-1:0] ST_LOAD  = 3'd3;
	localparam logic [ST_W-1:0] ST_DIV   = 3'd4;
	localparam logic [ST_W-1:0] ST_UREAD = 3'd5;
	localparam logic [ST_W-1:0] ST_UWRT  = 3'd6;

	localparam int IDX_W   = o2hbp_pkg::IDX_W;
	localparam int COUNT_W = o2hbp_pkg::COUNT_W;
	localparam int HASH_W  = o2hbp_pkg::HASH_W;

	logic [ST_W-1:0]   state_q;
	logic [IDX_W-1:0]  clr_q;
	logic [HASH_W-1:0] sum_q;
	logic [7:0]        pc_q;
	logic              bit_q;
	logic [IDX_W-1:0]  remembered_q;
	logic              out_valid_q;
	logic [o2hbp_pkg::PROB_W-1:0] out_data_q;

	logic              accept;
	logic              out_free;
	logic [HASH_W-1:0] hash;
	logic [IDX_W-1:0]  hash_idx;

	o2hbp_pkg::entry_t mem [o2hbp_pkg::TABLE_ENTRIES];
	o2hbp_pkg::entry_t rdata_q;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	o2hbp_pkg::entry_t mem_wdata;
	logic [IDX_W-1:0]  mem_raddr;

	logic [COUNT_W-1:0] n0_inc;
	logic [COUNT_W-1:0] n1_inc;
	logic               over;
	logic [COUNT_W:0]   n0_round;
	logic [COUNT_W:0]   n1_round;
	o2hbp_pkg::entry_t  upd_entry;

	logic                          div_start;
	logic                          div_done;
	logic [o2hbp_pkg::QUOT_W-1:0]  div_quot;
	logic [o2hbp_pkg::SUM_W-1:0]   div_denom;

	// handshake
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// hash: x*31 = (x << 5) - x, kept to 16 bits
	assign hash     = HASH_W'({sum_q[HASH_W-6:0], 5'b0} - sum_q) ^ {8'b0, pc_q};
	assign hash_idx = hash[IDX_W-1:0] & IDX_W'(o2hbp_pkg::TABLE_ENTRIES - 1);

	// count update for the coded bit, halving past the limit
	assign n0_inc   = bit_q ? rdata_q.n0 : COUNT_W'(rdata_q.n0 + 1'b1);
	assign n1_inc   = bit_q ? COUNT_W'(rdata_q.n1 + 1'b1) : rdata_q.n1;
	assign over     = bit_q ? (n1_inc > COUNT_W'(o2hbp_pkg::COUNT_LIMIT))
	                        : (n0_inc > COUNT_W'(o2hbp_pkg::COUNT_LIMIT));
	assign n0_round = {1'b0, n0_inc} + 1'b1;
	assign n1_round = {1'b0, n1_inc} + 1'b1;

	always_comb begin
		if (over) begin
			upd_entry.n0 = n0_round[COUNT_W:1];
			upd_entry.n1 = n1_round[COUNT_W:1];
		end else begin
			upd_entry.n0 = n0_inc;
			upd_entry.n1 = n1_inc;
		end
	end

	// table port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = remembered_q;
		mem_wdata = upd_entry;
		mem_raddr = remembered_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we       = 1'b1;
				mem_waddr    = clr_q;
				mem_wdata.n0 = COUNT_W'(1);
				mem_wdata.n1 = COUNT_W'(1);
			end
			ST_HASH: begin
				mem_raddr = hash_idx;
			end
			ST_UWRT: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// count table with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// single divider, used only by predicts
	assign div_start = (state_q == ST_LOAD);
	assign div_denom = {1'b0, rdata_q.n0} + {1'b0, rdata_q.n1};

	o2hbp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (rdata_q.n1),
		.denom  (div_denom),
		.done   (div_done),
		.quot   (div_quot)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			remembered_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// result register: load a finished quotient, or empty on acceptance
			if (state_q == ST_DIV && div_done && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(o2hbp_pkg::TABLE_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= (s_axis_tuser == o2hbp_pkg::OP_PREDICT) ? ST_HASH
						                                                     : ST_UREAD;
					end
				end
				ST_HASH: begin
					remembered_q <= hash_idx;
					state_q      <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_UREAD: begin
					state_q <= ST_UWRT;
				end
				ST_UWRT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// word capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q <= {s_axis_tdata[7:0], s_axis_tdata[7:0]} + {8'b0, s_axis_tdata[15:8]};
			pc_q  <= s_axis_tdata[23:16];
			bit_q <= s_axis_tdata[24];
		end
		if (state_q == ST_DIV && div_done && out_free) begin
			out_data_q <= o2hbp_pkg::PROB_W'(div_quot);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b0, out_data_q};

endmodule

// ===== bench/o2hbp_checker.sv =====
// checker for the order-2 hashed bit predictor: watches both streams, keeps its own
// count table and remembered index, and compares every probability word
// depends on o2hbp_pkg
`timescale 1ns / 1ps

module o2hbp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	// [7:0] older_byte, [15:8] previous_byte, [23:16] partial_byte,
	// [24] coded_bit, [31:25] zero
	input  logic [31:0] s_axis_tdata,
	// [0] operation
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [12:0] probability_one, [15:13] zero
	input  logic [15:0] m_axis_tdata,
	output int unsigned pending_results,
	output int unsigned mismatches
);

	localparam int IDX_W   = o2hbp_pkg::IDX_W;
	localparam int PROB_W  = o2hbp_pkg::PROB_W;
	localparam int COUNT_W = o2hbp_pkg::COUNT_W;

	// own copy of the count table and the index the last predict left behind
	o2hbp_pkg::entry_t bit_counts [o2hbp_pkg::TABLE_ENTRIES];
	logic [IDX_W-1:0]  held_index;

	// probabilities still owed by the block, oldest first
	logic [PROB_W-1:0] prob_due [$];

	task automatic report_mismatch(input string msg);
		$display("%0t ns o2hbp check: %s", $time, msg);
		mismatches++;
	endtask

	// index of an order-2 context: ((older*257 + previous)*31) xor partial, masked
	function automatic logic [IDX_W-1:0] context_index(input logic [7:0] older,
			input logic [7:0] previous, input logic [7:0] partial);
		logic [31:0] h;
		h = (({24'd0, older} * 32'd257 + {24'd0, previous}) * 32'd31) ^ {24'd0, partial};
		return IDX_W'(h & 32'(o2hbp_pkg::TABLE_ENTRIES - 1));
	endfunction

	// n1*scale/(n0+n1), half scale on an empty entry
	function automatic logic [PROB_W-1:0] prob_of(input o2hbp_pkg::entry_t e);
		logic [31:0] den;
		logic [31:0] q;
		den = 32'(e.n0) + 32'(e.n1);
		if (den == 0)
			q = 32'(o2hbp_pkg::PROB_SCALE / 2);
		else
			q = (32'(e.n1) * 32'(o2hbp_pkg::PROB_SCALE)) / den;
		return q[PROB_W-1:0];
	endfunction

	// apply one accepted word to the local state, queueing a probability for a predict
	task automatic take_word(input logic op, input logic [31:0] data);
		o2hbp_pkg::entry_t e;
		logic              one;
		if (op == o2hbp_pkg::OP_PREDICT) begin
			held_index = context_index(data[7:0], data[15:8], data[23:16]);
			prob_due.push_back(prob_of(bit_counts[held_index]));
		end else begin
			e   = bit_counts[held_index];
			one = data[24];
			if (one) begin
				e.n1 = e.n1 + 1'b1;
			end else begin
				e.n0 = e.n0 + 1'b1;
			end
			// halve both counts, rounding up, once the bumped one passes the limit
			if ((one ? e.n1 : e.n0) > COUNT_W'(o2hbp_pkg::COUNT_LIMIT)) begin
				e.n0 = COUNT_W'(({1'b0, e.n0} + 1'b1) >> 1);
				e.n1 = COUNT_W'(({1'b0, e.n1} + 1'b1) >> 1);
			end
			bit_counts[held_index] = e;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < o2hbp_pkg::TABLE_ENTRIES; i++) begin
				bit_counts[i].n0 = COUNT_W'(1);
				bit_counts[i].n1 = COUNT_W'(1);
			end
			held_index = '0;
			prob_due.delete();
			pending_results = 0;
			mismatches = 0;
		end else begin
			// result side first: a word leaving now belongs to an earlier predict
			if (m_axis_tvalid && m_axis_tready) begin
				if (prob_due.size() == 0) begin
					report_mismatch($sformatf("result word 0x%h with nothing due", m_axis_tdata));
				end else begin
					logic [PROB_W-1:0] want;
					want = prob_due.pop_front();
					if (m_axis_tdata[PROB_W-1:0] !== want)
						report_mismatch($sformatf("probability_one %0d, expected %0d",
							m_axis_tdata[PROB_W-1:0], want));
					if (m_axis_tdata[15:PROB_W] !== '0)
						report_mismatch($sformatf("pad bits 0x%h not zero",
							m_axis_tdata[15:PROB_W]));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				take_word(s_axis_tuser, s_axis_tdata);
			pending_results = prob_due.size();
		end
	end

endmodule

// ===== bench/tb_order2_hashed_bit_predictor.sv =====
// testbench top for the order-2 hashed bit predictor: clock, reset, stimulus, verdict
// depends on o2hbp_pkg, order2_hashed_bit_predictor and o2hbp_checker
`timescale 1ns / 1ps

module tb_order2_hashed_bit_predictor;

	localparam int          WORD_TARGET = 1900;
	localparam int          IDLE_PCT    = 14;
	localparam int unsigned CYCLE_LIMIT = 400_000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// [7:0] older_byte, [15:8] previous_byte, [23:16] partial_byte,
	// [24] coded_bit, [31:25] zero
	logic [31:0] s_axis_tdata;
	// [0] operation
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// [12:0] probability_one, [15:13] zero
	logic [15:0] m_axis_tdata;

	int unsigned pending_results;
	int unsigned mismatches;
	int unsigned cycles = 0;
	int          words_sent = 0;
	bit          calm = 1'b0;

	order2_hashed_bit_predictor u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	o2hbp_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.pending_results (pending_results),
		.mismatches      (mismatches)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog, also catches probabilities that never arrive
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_order2_hashed_bit_predictor: done, errors");
			$finish;
		end
	end

	// result side back-pressure, none during the calm stretch
	always @(negedge clk)
		m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// offer one word from a falling edge and hold it until it is taken
	task automatic send_word(input logic op, input logic [7:0] older,
			input logic [7:0] previous, input logic [7:0] partial, input logic coded);
		calm = (words_sent >= 800 && words_sent < 1100);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {7'd0, coded, partial, previous, older};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic predict(input logic [7:0] older, input logic [7:0] previous,
			input logic [7:0] partial);
		send_word(o2hbp_pkg::OP_PREDICT, older, previous, partial,
			1'($urandom_range(0, 1)));
	endtask

	// byte fields are ignored on an update, so they carry noise
	task automatic update(input logic coded);
		send_word(o2hbp_pkg::OP_UPDATE, any_byte(), any_byte(), any_byte(), coded);
	endtask

	// hold the sender off until every owed probability has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_results != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [7:0] hot_older;
		logic [7:0] hot_previous;
		logic [7:0] hot_partial;
		logic       favoured;
		int         pick;
		int         run_len;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = o2hbp_pkg::OP_PREDICT;
		s_axis_tdata  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// update before any predict lands on entry 0
		update(1'b1);
		predict(8'd0, 8'd0, 8'd0);
		update(1'b0);
		predict(8'd0, 8'd0, 8'd0);
		// all-ones context, both bits counted
		predict(8'hff, 8'hff, 8'hff);
		update(1'b1);
		update(1'b1);
		update(1'b0);
		predict(8'hff, 8'hff, 8'hff);
		// marker-only partial byte and mixed extremes
		predict(8'd0, 8'd0, 8'd1);
		predict(8'hff, 8'd0, 8'h80);
		predict(8'd0, 8'hff, 8'hff);
		predict(8'h80, 8'd1, 8'd0);
		predict(8'haa, 8'h55, 8'haa);
		predict(8'h55, 8'haa, 8'h55);
		// coded_bit on a predict and bytes on an update are ignored
		send_word(o2hbp_pkg::OP_PREDICT, 8'd0, 8'd0, 8'd1, 1'b1);
		send_word(o2hbp_pkg::OP_UPDATE, 8'hff, 8'hff, 8'hff, 1'b0);
		send_word(o2hbp_pkg::OP_PREDICT, 8'd0, 8'd0, 8'd1, 1'b0);
		drain();

		// one hot context takes long biased runs so its count crosses the limit
		hot_older    = any_byte();
		hot_previous = any_byte();
		hot_partial  = any_byte();
		favoured     = 1'($urandom_range(0, 1));
		while (words_sent < WORD_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				// ordinary coding step: a predict and the bits that follow it
				predict(any_byte(), any_byte(), any_byte());
				run_len = $urandom_range(1, 3);
				repeat (run_len) update(1'($urandom_range(0, 1)));
			end else if (pick < 85) begin
				predict(hot_older, hot_previous, hot_partial);
				run_len = $urandom_range(5, 40);
				repeat (run_len)
					update(($urandom_range(0, 99) < 94) ? favoured : ~favoured);
			end else begin
				// lone word of either kind
				send_word(1'($urandom_range(0, 1)), any_byte(), any_byte(), any_byte(),
					1'($urandom_range(0, 1)));
			end
			if (words_sent >= 1400 && words_sent < 1440)
				drain();
		end
		s_axis_tvalid <= 1'b0;

		while (pending_results != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb_order2_hashed_bit_predictor: done, clean");
		else
			$display("tb_order2_hashed_bit_predictor: done, errors");
		$finish;
	end

endmodule
